### rtl/timestamp_kway_merge_defines.svh
// Assertion macros used by the timestamp merge RTL.
`ifndef TIMESTAMP_KWAY_MERGE_DEFINES_SVH
`define TIMESTAMP_KWAY_MERGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TKM_ASSERT_IMPLY(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("timestamp merge check failed");

// Next-cycle implication, disabled while reset is high.
`define TKM_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("timestamp merge check failed");

`endif

### rtl/tkm_pkg.sv
// Types and constants of the timestamp merge block.
package tkm_pkg;

  // Defaults of the top-level parameters
  localparam int NUM_SOURCES_DEF   = 8;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int TIME_W   = 64;
  localparam int SRC_FW   = 3;
  localparam int HANDLE_W = 32;
  localparam int CMP8_W   = 8;

  // Stream widths
  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 104;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int ACTIVE_W    = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_GPS_MODE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_SOURCES = 8'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_WRITE,
    ST_CHECK,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } tkm_state_t;

endpackage

### rtl/timestamp_kway_merge.sv
// Top level of the timestamp merge: k-way merge of time-stamped record streams.
//
// Merges up to NUM_SOURCES record streams into one stream ordered by signed time, lowest
// source first on ties. One input beat is taken at a time: an offset read, an offset
// update, a head write and a readiness check, which ends the beat when nothing can be
// emitted; else a scan of the head memory follows, one slot per cycle through the shared
// 65-bit subtractor, which also forms the GPS offset and corrected time, then a compare
// tail step and an emit step. The emit step repeats while the output register still holds
// an unaccepted beat. An emitted beat waits in the output register; the next input beat
// is taken while it waits. No clearing pass after reset; input and configuration are not
// ready while reset is high.
`include "timestamp_kway_merge_defines.svh"

module timestamp_kway_merge
  import tkm_pkg::*;
#(
  parameter int NUM_SOURCES   = NUM_SOURCES_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // source[2:0], node_time[66:3], gps_time[130:67], payload_handle[162:131], zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // end_of_source[0], is_gps[1]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // source_out[2:0], merged_time[66:3], payload_out[98:67], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SRC_W = $clog2(NUM_SOURCES);
  localparam int CNT_W = $clog2(NUM_SOURCES + 1);
  localparam int ROW_W = PAYLOAD_WIDTH + TIME_W;

  tkm_state_t state, state_next;

  // Configuration registers
  logic                gps_mode;
  logic [ACTIVE_W-1:0] active_sources;

  // Per-source flags
  logic [NUM_SOURCES-1:0] head_valid;
  logic [NUM_SOURCES-1:0] source_ended;
  logic [NUM_SOURCES-1:0] offset_written;
  logic [NUM_SOURCES-1:0] active_mask;

  // Memories
  logic [ROW_W-1:0]  head_mem [NUM_SOURCES];
  logic [TIME_W-1:0] offset_mem [NUM_SOURCES];

  // Captured input beat
  logic [SRC_W-1:0]         item_idx;
  logic [CMP8_W-1:0]        item_src8;
  logic                     item_eos;
  logic                     item_gps;
  logic [TIME_W-1:0]        item_ntime;
  logic [TIME_W-1:0]        item_gtime;
  logic [PAYLOAD_WIDTH-1:0] item_payload;

  // Offset path
  logic [TIME_W-1:0] offset_rd;
  logic              offset_rd_ok;
  logic [TIME_W-1:0] offset_cur;
  logic              rec_ok;

  // Scan path
  logic [CNT_W-1:0]  rd_idx;
  logic [ROW_W-1:0]  rd_row;
  logic [SRC_W-1:0]  cmp_idx;
  logic              cmp_live;
  logic              best_found;
  logic [SRC_W-1:0]  best_idx;
  logic [ROW_W-1:0]  best_row;

  // Shared subtractor
  logic [TIME_W-1:0] op_a, op_b;
  logic [TIME_W:0]   diff;

  // Misc combinational
  logic [CMP8_W-1:0]        src_in8;
  logic [SRC_W-1:0]         src_in_idx;
  logic [CMP8_W-1:0]        n8;
  logic [CNT_W-1:0]         n_cnt;
  logic                     in_range;
  logic                     all_ready;
  logic                     any_head;
  logic                     slot_free;
  logic [TIME_W-1:0]        off_eff;
  logic [TIME_W-1:0]        head_time_new;
  logic [TIME_W-1:0]        pay_in64;
  logic [TIME_W-1:0]        pay_out64;
  logic [CMP8_W-1:0]        best8;

  // Count of active sources, saturated at NUM_SOURCES
  always_comb begin
    n8 = (CMP8_W'(active_sources) > CMP8_W'(NUM_SOURCES)) ? CMP8_W'(NUM_SOURCES)
                                                          : CMP8_W'(active_sources);
    n_cnt = n8[CNT_W-1:0];
    for (int i = 0; i < NUM_SOURCES; i++) begin
      active_mask[i] = CMP8_W'(i) < n8;
    end
  end

  assign src_in8    = CMP8_W'(s_tdata[SRC_FW-1:0]);
  assign src_in_idx = src_in8[SRC_W-1:0];
  assign in_range   = item_src8 < n8;
  assign off_eff    = offset_rd_ok ? offset_rd : '0;
  assign pay_in64   = TIME_W'(s_tdata[SRC_FW+2*TIME_W +: HANDLE_W]);

  // Emit condition over the per-source flags
  assign all_ready = &(head_valid | source_ended | ~active_mask);
  assign any_head  = |(head_valid & active_mask);
  assign slot_free = !m_tvalid || m_tready;

  // Shared subtractor: offset, corrected time, or scan compare
  always_comb begin
    case (state)
      ST_OFFSET: begin
        op_a = item_ntime;
        op_b = item_gtime;
      end
      ST_WRITE: begin
        op_a = item_ntime;
        op_b = offset_cur;
      end
      default: begin
        op_a = rd_row[TIME_W-1:0];
        op_b = best_row[TIME_W-1:0];
      end
    endcase
    diff = {op_a[TIME_W-1], op_a} - {op_b[TIME_W-1], op_b};
  end

  assign head_time_new = gps_mode ? diff[TIME_W-1:0] : item_ntime;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) state_next = ST_OFFSET;
      end
      ST_OFFSET: state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (all_ready && any_head) ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (rd_idx == n_cnt - CNT_W'(1)) state_next = ST_TAIL;
      end
      ST_TAIL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign cfg_ready = !rst;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gps_mode       <= 1'b0;
      active_sources <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GPS_MODE:       gps_mode       <= cfg_data[0];
        CFG_ACTIVE_SOURCES: active_sources <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input beat and read its source's offset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      item_src8    <= src_in8;
      item_idx     <= src_in_idx;
      item_eos     <= s_tuser[0];
      item_gps     <= s_tuser[1];
      item_ntime   <= s_tdata[SRC_FW +: TIME_W];
      item_gtime   <= s_tdata[SRC_FW+TIME_W +: TIME_W];
      item_payload <= pay_in64[PAYLOAD_WIDTH-1:0];
      offset_rd    <= offset_mem[src_in_idx];
      offset_rd_ok <= offset_written[src_in_idx];
    end
  end

  // Decide on the record and form the new offset
  always_ff @(posedge clk) begin
    if (state == ST_OFFSET) begin
      rec_ok     <= in_range && !item_eos && !head_valid[item_idx] &&
                    !source_ended[item_idx];
      offset_cur <= (gps_mode && item_gps) ? diff[TIME_W-1:0] : off_eff;
    end
  end

  // Offset memory write
  always_ff @(posedge clk) begin
    if (state == ST_WRITE && rec_ok && gps_mode && item_gps) begin
      offset_mem[item_idx] <= offset_cur;
    end
  end

  // Head memory write and scan read
  always_ff @(posedge clk) begin
    if (state == ST_WRITE && rec_ok) begin
      head_mem[item_idx] <= {item_payload, head_time_new};
    end
    if (state == ST_SCAN) begin
      rd_row <= head_mem[rd_idx[SRC_W-1:0]];
    end
  end

  // Per-source flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid     <= '0;
      source_ended   <= '0;
      offset_written <= '0;
    end else begin
      if (state == ST_OFFSET && in_range && item_eos) begin
        source_ended[item_idx] <= 1'b1;
      end
      if (state == ST_WRITE && rec_ok) begin
        head_valid[item_idx] <= 1'b1;
        if (gps_mode && item_gps) offset_written[item_idx] <= 1'b1;
      end
      if (state == ST_EMIT && slot_free) begin
        head_valid[best_idx] <= 1'b0;
      end
    end
  end

  // Scan: issue one read a cycle, compare each row in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      rd_idx     <= '0;
      best_found <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        rd_idx  <= rd_idx + CNT_W'(1);
        cmp_idx <= rd_idx[SRC_W-1:0];
      end
      // Keep the strictly smaller time so ties stay with the lower source
      if (cmp_live && head_valid[cmp_idx] && (!best_found || diff[TIME_W])) begin
        best_found <= 1'b1;
        best_idx   <= cmp_idx;
        best_row   <= rd_row;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign pay_out64 = TIME_W'(best_row[ROW_W-1:TIME_W]);
  assign best8     = CMP8_W'(best_idx);

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      m_tdata <= {5'd0, pay_out64[HANDLE_W-1:0], best_row[TIME_W-1:0], best8[SRC_FW-1:0]};
    end
  end

  // Checks
  `TKM_ASSERT_NEXT(a_scan_finds_head, clk, rst, state == ST_TAIL, best_found)
  `TKM_ASSERT_NEXT(a_emit_frees_slot, clk, rst, state == ST_EMIT && slot_free, m_tvalid && !head_valid[$past(best_idx)])
  `TKM_ASSERT_NEXT(a_write_sets_head, clk, rst, state == ST_WRITE && rec_ok, head_valid[$past(item_idx)])
  `TKM_ASSERT_IMPLY(a_scan_has_ready, clk, rst, state == ST_SCAN, all_ready && any_head)

endmodule

### tb/sv/timestamp_kway_merge_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the timestamp merge block: directed rows, then random streams.
module timestamp_kway_merge_test;
  import tkm_pkg::*;

  localparam int SOURCES       = NUM_SOURCES_DEF;
  localparam int SETTLE_CYCLES = 2 * SOURCES + 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IN_USED_W     = SRC_FW + 2 * TIME_W + HANDLE_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'd2;
  localparam logic [TIME_W-1:0] STAMP_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [TIME_W-1:0] STAMP_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [TIME_W-1:0] STAMP_NEG1 = '1;

  typedef struct packed {
    logic [SRC_FW-1:0]   src;
    logic                eos;
    logic [TIME_W-1:0]   node_stamp;
    logic                gps;
    logic [TIME_W-1:0]   gps_stamp;
    logic [HANDLE_W-1:0] handle;
  } record_t;

  typedef struct packed {
    logic [SRC_FW-1:0]   src;
    logic [TIME_W-1:0]   stamp;
    logic [HANDLE_W-1:0] handle;
  } merged_t;

  // ROW_PREDICT rows are checked against the merge predictor, ROW_NONE and ROW_RESULT rows carry their result
  typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    record_t                rec;
    merged_t                want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bit                idle_on = 1'b1;
  int                sink_stall = 0;
  int                cycle_count = 0;
  int                faults = 0;
  logic [TIME_W-1:0] stamp_base = '0;
  merged_t           merged_due [$];

  // Merge state as the predictor sees it
  logic                     gps_on;
  logic [ACTIVE_W-1:0]      active_reg;
  logic                     head_live   [SOURCES];
  logic signed [TIME_W-1:0] head_stamp  [SOURCES];
  logic [HANDLE_W-1:0]      head_handle [SOURCES];
  logic [TIME_W-1:0]        gps_offset  [SOURCES];
  logic                     src_done    [SOURCES];

  timestamp_kway_merge dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int live_sources();
    return (active_reg > SOURCES) ? SOURCES : int'(active_reg);
  endfunction

  function automatic int count_set(input logic flags [SOURCES]);
    int i;
    int n;
    n = 0;
    for (i = 0; i < SOURCES; i++) n += int'(flags[i]);
    return n;
  endfunction

  // Apply one input beat to the merge state; return 1 with the emitted record if any
  function automatic bit merge_predict(input record_t r, output merged_t res);
    int i;
    int n;
    int best;
    bit full;
    bit found;
    logic [TIME_W-1:0] t;
    n = live_sources();
    res = '0;
    if (int'(r.src) < n) begin
      if (r.eos) begin
        src_done[r.src] = 1'b1;
      end else if (!head_live[r.src] && !src_done[r.src]) begin
        t = r.node_stamp;
        if (gps_on) begin
          if (r.gps) gps_offset[r.src] = r.node_stamp - r.gps_stamp;
          t = r.node_stamp - gps_offset[r.src];
        end
        head_live[r.src]   = 1'b1;
        head_stamp[r.src]  = t;
        head_handle[r.src] = r.handle;
      end
    end
    // every active source needs a head or an end before the least head goes out
    full = 1'b1;
    found = 1'b0;
    best = 0;
    for (i = 0; i < n; i++) begin
      if (!head_live[i] && !src_done[i]) begin
        full = 1'b0;
        break;
      end
      if (head_live[i] && (!found || head_stamp[i] < head_stamp[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (!full || !found) return 1'b0;
    res.src    = SRC_FW'(best);
    res.stamp  = head_stamp[best];
    res.handle = head_handle[best];
    head_live[best] = 1'b0;
    return 1'b1;
  endfunction

  function automatic record_t mk_rec(input logic [SRC_FW-1:0] src, input logic eos,
                                     input logic [TIME_W-1:0] node, input logic gps,
                                     input logic [TIME_W-1:0] gps_t,
                                     input logic [HANDLE_W-1:0] handle);
    record_t r;
    r.src = src;
    r.eos = eos;
    r.node_stamp = node;
    r.gps = gps;
    r.gps_stamp = gps_t;
    r.handle = handle;
    return r;
  endfunction

  function automatic merged_t mk_out(input logic [SRC_FW-1:0] src,
                                     input logic [TIME_W-1:0] stamp,
                                     input logic [HANDLE_W-1:0] handle);
    merged_t m;
    m.src = src;
    m.stamp = stamp;
    m.handle = handle;
    return m;
  endfunction

  function automatic plan_row_t mk_item(input row_kind_t kind, input record_t r,
                                        input merged_t want);
    plan_row_t row;
    row.kind = kind;
    row.reg_index = '0;
    row.reg_value = '0;
    row.rec = r;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t mk_reg(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.kind = ROW_REG;
    row.reg_index = idx;
    row.reg_value = val;
    row.rec = '0;
    row.want = '0;
    return row;
  endfunction

  function automatic logic [TIME_W-1:0] pick_stamp();
    logic [TIME_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = STAMP_MIN;
          1: v = STAMP_MAX;
          2: v = '0;
          default: v = STAMP_NEG1;
        endcase
      end
      1, 2, 3: v = {$urandom, $urandom};
      // near a shared base so that ties show up
      default: v = stamp_base + TIME_W'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  // Prefer a source whose slot is open so that the merge keeps moving
  function automatic logic [SRC_FW-1:0] pick_source();
    int open_src [$];
    int i;
    int n;
    n = live_sources();
    for (i = 0; i < n; i++) begin
      if (!head_live[i] && !src_done[i]) open_src.push_back(i);
    end
    if (open_src.size() != 0 && $urandom_range(0, 3) != 0)
      return SRC_FW'(open_src[$urandom_range(0, open_src.size() - 1)]);
    return SRC_FW'($urandom_range(0, SOURCES - 1));
  endfunction

  function automatic record_t random_record();
    record_t r;
    r.src = pick_source();
    // end marks only on unused sources here, where they must be ignored
    r.eos = (int'(r.src) >= live_sources()) && ($urandom_range(0, 3) == 0);
    r.node_stamp = pick_stamp();
    r.gps = ($urandom_range(0, 3) == 0);
    r.gps_stamp = pick_stamp();
    r.handle = $urandom;
    return r;
  endfunction

  // Send one beat, then log what it should produce; rows with a typed result override it
  task automatic send_item(input record_t r, input bit typed, input bit typed_emit,
                           input merged_t typed_res);
    merged_t res;
    bit emit;
    s_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, r.handle, r.gps_stamp, r.node_stamp, r.src};
    s_tuser  <= {r.gps, r.eos};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    emit = merge_predict(r, res);
    if (typed) begin
      emit = typed_emit;
      res = typed_res;
    end
    if (emit) merged_due.push_back(res);
    // drop valid for a short burst now and then
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Leave cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GPS_MODE) gps_on = val[0];
    else if (idx == CFG_ACTIVE_SOURCES) active_reg = val[ACTIVE_W-1:0];
  endtask

  // Hold the input until every record is out and the sequencer has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (merged_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure(input logic gps, input logic [ACTIVE_W-1:0] act);
    settle();
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_UNUSED + CFG_INDEX_W'($urandom_range(0, 253)), CFG_DATA_W'($urandom));
    write_reg(CFG_GPS_MODE, {7'($urandom), gps});
    write_reg(CFG_ACTIVE_SOURCES, {4'($urandom), act});
    cfg_valid <= 1'b0;
  endtask

  // Output backpressure in random bursts, off while idling is disabled
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      m_tready <= 1'b1;
      sink_stall <= 0;
    end else if (sink_stall != 0) begin
      m_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready <= 1'b0;
      sink_stall <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic bit field_bad(input string what, input logic [TIME_W-1:0] want,
                                   input logic [TIME_W-1:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    return 1'b1;
  endfunction

  // Compare each output beat with the oldest pending record
  always @(posedge clk) begin : check_output
    merged_t got;
    merged_t due;
    if (!rst && m_tvalid && m_tready) begin
      got.src    = m_tdata[SRC_FW-1:0];
      got.stamp  = m_tdata[SRC_FW +: TIME_W];
      got.handle = m_tdata[SRC_FW + TIME_W +: HANDLE_W];
      if (merged_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual src %0d stamp %h handle %h",
                 $time, got.src, got.stamp, got.handle);
        faults++;
      end else begin
        due = merged_due.pop_front();
        if (field_bad("source_out", TIME_W'(due.src), TIME_W'(got.src))) faults++;
        if (field_bad("merged_time", due.stamp, got.stamp)) faults++;
        if (field_bad("payload_out", TIME_W'(due.handle), TIME_W'(got.handle))) faults++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t           plan [$];
    record_t             r;
    logic [ACTIVE_W-1:0] phase_active [8];
    logic                phase_gps [8];
    int                  i;
    int                  k;
    int                  p;

    gps_on = 1'b0;
    active_reg = ACTIVE_RESET;
    for (i = 0; i < SOURCES; i++) begin
      head_live[i] = 1'b0;
      head_stamp[i] = '0;
      head_handle[i] = '0;
      gps_offset[i] = '0;
      src_done[i] = 1'b0;
    end
    phase_active = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8};
    phase_gps = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    // lone head after reset waits for the other sources
    plan.push_back(mk_item(ROW_NONE, mk_rec(0, 0, '0, 0, '0, '0), '0));
    plan.push_back(mk_reg(CFG_ACTIVE_SOURCES, 8'd2));
    plan.push_back(mk_item(ROW_RESULT, mk_rec(1, 0, STAMP_MAX, 0, '0, '1),
                           mk_out(0, '0, '0)));
    // most negative time; GPS fields are ignored outside GPS mode
    plan.push_back(mk_item(ROW_RESULT, mk_rec(0, 0, STAMP_MIN, 1, STAMP_MAX, 32'hA5A5_A5A5),
                           mk_out(0, STAMP_MIN, 32'hA5A5_A5A5)));
    // record for a source whose head is pending is dropped
    plan.push_back(mk_item(ROW_NONE, mk_rec(1, 0, 64'd5, 0, '0, 32'h1234), '0));
    // equal times: lower source wins
    plan.push_back(mk_item(ROW_RESULT, mk_rec(0, 0, STAMP_MAX, 0, '0, 32'h1),
                           mk_out(0, STAMP_MAX, 32'h1)));
    // inactive sources are ignored, end mark included
    plan.push_back(mk_item(ROW_NONE, mk_rec(5, 0, 64'd7, 0, '0, 32'h5), '0));
    plan.push_back(mk_item(ROW_NONE, mk_rec(6, 1, '0, 0, '0, '0), '0));
    plan.push_back(mk_item(ROW_RESULT, mk_rec(0, 0, STAMP_NEG1, 0, '0, 32'h5A5A_5A5A),
                           mk_out(0, STAMP_NEG1, 32'h5A5A_5A5A)));
    // GPS mode: a GPS record comes out at its GPS time
    plan.push_back(mk_reg(CFG_GPS_MODE, 8'd1));
    plan.push_back(mk_item(ROW_RESULT, mk_rec(0, 0, 64'd100, 1, 64'd1000, 32'h10),
                           mk_out(0, 64'd1000, 32'h10)));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(0, 0, 64'd50, 0, '0, 32'h11), '0));
    // offset wraps around
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(0, 0, STAMP_MIN, 1, 64'd1, 32'h12), '0));
    // dropped GPS record leaves the offset alone
    plan.push_back(mk_item(ROW_NONE, mk_rec(1, 0, '0, 1, 64'd77, 32'h13), '0));
    // out-of-range source count saturates to all sources
    plan.push_back(mk_reg(CFG_ACTIVE_SOURCES, 8'hFF));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(2, 0, 64'd3, 1, STAMP_MIN, 32'h20), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(3, 0, 64'd3, 0, '0, 32'h30), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(4, 0, 64'd3, 1, 64'd3, 32'h40), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(5, 0, STAMP_MIN, 0, '0, 32'h50), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(6, 0, 64'd20, 0, '0, 32'hFFFF_FFFF), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(7, 0, -64'sd20, 0, '0, 32'h70), '0));
    plan.push_back(mk_item(ROW_PREDICT, mk_rec(0, 0, '0, 0, '0, 32'h80), '0));
    // no active source: nothing is ever emitted
    plan.push_back(mk_reg(CFG_ACTIVE_SOURCES, 8'd0));
    plan.push_back(mk_item(ROW_NONE, mk_rec(2, 0, 64'd9, 0, '0, 32'h22), '0));
    plan.push_back(mk_reg(CFG_UNUSED, 8'hFF));
    plan.push_back(mk_reg(CFG_GPS_MODE, 8'hFE));
    plan.push_back(mk_reg(CFG_ACTIVE_SOURCES, 8'd8));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // walk the directed rows
    for (k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == ROW_REG) begin
        if (k == 0 || plan[k-1].kind != ROW_REG) settle();
        write_reg(plan[k].reg_index, plan[k].reg_value);
      end else begin
        cfg_valid <= 1'b0;
        send_item(plan[k].rec, plan[k].kind != ROW_PREDICT, plan[k].kind == ROW_RESULT,
                  plan[k].want);
      end
    end
    cfg_valid <= 1'b0;

    // random phases over a spread of settings
    for (p = 0; p < 8; p++) begin
      reconfigure(phase_gps[p], phase_active[p]);
      idle_on = ($urandom_range(0, 3) != 0);
      stamp_base = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
                                               : TIME_W'($urandom_range(0, 1000));
      for (k = 0; k < ((phase_active[p] == 0) ? 20 : 75); k++)
        send_item(random_record(), 1'b0, 1'b0, '0);
    end

    // wind down without idling: end sources one at a time, then drain the heads
    reconfigure(1'($urandom_range(0, 1)), 4'd8);
    idle_on = 1'b0;
    while (count_set(src_done) != SOURCES) begin
      r = random_record();
      if ($urandom_range(0, 9) == 0) begin
        r.eos = 1'b1;
        r.src = SRC_FW'($urandom_range(0, SOURCES - 1));
      end
      send_item(r, 1'b0, 1'b0, '0);
    end
    while (count_set(head_live) != 0) begin
      r = random_record();
      r.eos = 1'b1;
      send_item(r, 1'b0, 1'b0, '0);
    end
    // records for ended sources are dropped
    repeat (4) send_item(random_record(), 1'b0, 1'b0, '0);

    settle();
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
